>>> hw/rtl/mpbp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT packet body parser package
// Shared types, packet codes and the protocol name table for the parser.
// ----------------------------------------------------------------------------
package mpbp_pkg;

    // Control packet type codes as they appear in the fixed header.
    localparam logic [3:0] TYPE_CONNECT     = 4'd1;
    localparam logic [3:0] TYPE_CONNACK     = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH     = 4'd3;
    localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
    localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] TYPE_PINGREQ     = 4'd12;

    // Reported packet kinds.
    localparam logic [2:0] PK_OTHER       = 3'd0;
    localparam logic [2:0] PK_CONNECT     = 3'd1;
    localparam logic [2:0] PK_CONNACK     = 3'd2;
    localparam logic [2:0] PK_PUBLISH     = 3'd3;
    localparam logic [2:0] PK_SUBSCRIBE   = 3'd4;
    localparam logic [2:0] PK_UNSUBSCRIBE = 3'd5;
    localparam logic [2:0] PK_PING        = 3'd6;

    // Kinds of a streamed byte.
    localparam logic [1:0] BK_NONE      = 2'd0;
    localparam logic [1:0] BK_CLIENT_ID = 2'd1;
    localparam logic [1:0] BK_TOPIC     = 2'd2;
    localparam logic [1:0] BK_MESSAGE   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_CNAMELEN = 4'd1,
        PH_CNAME    = 4'd2,
        PH_CSKIP    = 4'd3,
        PH_CKEEP    = 4'd4,
        PH_CIDLEN   = 4'd5,
        PH_CID      = 4'd6,
        PH_PTLEN    = 4'd7,
        PH_PTOPIC   = 4'd8,
        PH_PMSG     = 4'd9,
        PH_PID      = 4'd10,
        PH_TLEN     = 4'd11,
        PH_TOPIC    = 4'd12,
        PH_SQOS     = 4'd13,
        PH_TAIL     = 4'd14,
        PH_HALT     = 4'd15
    } t_phase;

    typedef struct packed {
        logic [3:0] packet_type;
        logic [7:0] body_byte;
        logic       byte_present;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [7:0]  byte_value;
        logic [7:0]  topic_entry;
        logic        packet_done;
        logic        accepted;
        logic        malformed;
        logic [2:0]  packet_kind;
        logic [15:0] keep_alive;
        logic [7:0]  chosen_entry;
    } t_result;

    // Characters of the protocol name "MQTT".
    function automatic logic [7:0] proto_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h4D;
            2'd1: c = 8'h51;
            2'd2: c = 8'h54;
            2'd3: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/mqtt_packet_body_parser_top.sv
// ----------------------------------------------------------------------------
// MQTT packet body parser
// Parses MQTT control packet bodies one byte per request and streams the
// client id, topic and message bytes with a verdict on the last byte.
// ----------------------------------------------------------------------------
// Each request produces exactly one result: the request is held in the input register
// and parsed, and its result is held in the result register. The
// parser takes one request every cycle as long as the result side drains;
// the rate is set by the combinational parse step that updates the packet
// state between the two registers. The input side stalls only when both
// registers are full and the result is stalled, and during reset.
module mqtt_packet_body_parser_top
    import mpbp_pkg::*;
#(
    parameter int unsigned ENTRY_INDEX_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_packet_type,
    input  logic [7:0]  i_body_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_byte_value,
    output logic [7:0]  o_topic_entry,
    output logic        o_packet_done,
    output logic        o_accepted,
    output logic        o_malformed,
    output logic [2:0]  o_packet_kind,
    output logic [15:0] o_keep_alive,
    output logic [7:0]  o_chosen_entry
);

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_result;
    t_result s_result;
    logic    out_free;
    logic    step;
    logic    in_take;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && out_free;
    assign o_in_stall = !i_rst_n || (r_in_vld && !out_free);
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.packet_type  <= i_packet_type;
            r_item.body_byte    <= i_body_byte;
            r_item.byte_present <= i_byte_present;
            r_item.last_byte    <= i_last_byte;
        end
    end

    mpbp_parse_core #(
        .ENTRY_INDEX_MAX(ENTRY_INDEX_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .o_result (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= s_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_byte_kind    = r_result.byte_kind;
    assign o_byte_value   = r_result.byte_value;
    assign o_topic_entry  = r_result.topic_entry;
    assign o_packet_done  = r_result.packet_done;
    assign o_accepted     = r_result.accepted;
    assign o_malformed    = r_result.malformed;
    assign o_packet_kind  = r_result.packet_kind;
    assign o_keep_alive   = r_result.keep_alive;
    assign o_chosen_entry = r_result.chosen_entry;

endmodule

>>> hw/rtl/mpbp_parse_core.sv
// ----------------------------------------------------------------------------
// MQTT parser core
// Holds the per-packet parse state and works out the result of one request
// in a single combinational pass; state advances when i_step is high.
// ----------------------------------------------------------------------------
module mpbp_parse_core
    import mpbp_pkg::*;
#(
    parameter int unsigned ENTRY_INDEX_MAX = 255
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int unsigned ENTRY_CAP_INT = (ENTRY_INDEX_MAX > 255) ? 255 : ENTRY_INDEX_MAX;
    localparam logic [7:0]  ENTRY_CAP     = 8'(ENTRY_CAP_INT);

    t_phase      r_phase, n_phase;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_keep, n_keep;
    logic [7:0]  r_entry, n_entry;
    logic        r_err, n_err;
    logic        r_hit, n_hit;
    logic [3:0]  r_type, n_type;

    logic [1:0]  s_kind;
    logic [7:0]  s_topic_entry;

    always_comb begin : next_state
        t_phase      ph;
        logic [15:0] rem;
        logic [15:0] rem_dec;
        logic [15:0] len;
        logic        done;
        logic [7:0]  b;

        b = i_item.body_byte;

        // A packet starts on the first request after idle.
        if (r_phase == PH_IDLE) begin
            n_type  = i_item.packet_type;
            n_err   = 1'b0;
            n_hit   = 1'b0;
            n_keep  = '0;
            n_entry = '0;
            n_shift = '0;
            unique case (i_item.packet_type)
                TYPE_CONNECT: begin
                    ph  = PH_CNAMELEN;
                    rem = 16'd2;
                end
                TYPE_PUBLISH: begin
                    ph  = PH_PTLEN;
                    rem = 16'd2;
                end
                TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE: begin
                    ph  = PH_PID;
                    rem = 16'd2;
                end
                default: begin
                    ph  = PH_TAIL;
                    rem = '0;
                end
            endcase
        end else begin
            n_type  = r_type;
            n_err   = r_err;
            n_hit   = r_hit;
            n_keep  = r_keep;
            n_entry = r_entry;
            n_shift = r_shift;
            ph      = r_phase;
            rem     = r_rem;
        end

        done    = (rem <= 16'd1);
        rem_dec = done ? 16'd0 : rem - 16'd1;
        len     = {n_shift, b};

        n_phase       = ph;
        n_rem         = rem;
        s_kind        = BK_NONE;
        s_topic_entry = '0;

        if (i_item.byte_present) begin
            unique case (ph)
                PH_CNAMELEN, PH_CIDLEN, PH_PTLEN, PH_PID, PH_TLEN: begin
                    n_rem = rem_dec;
                    if (!done) begin
                        n_shift = b;
                    end else begin
                        n_shift = '0;
                        unique case (ph)
                            PH_CNAMELEN: begin
                                if (len != 16'd4) begin
                                    n_err   = 1'b1;
                                    n_phase = PH_HALT;
                                    n_rem   = '0;
                                end else begin
                                    n_phase = PH_CNAME;
                                    n_rem   = 16'd4;
                                end
                            end
                            PH_CIDLEN: begin
                                n_phase = (len == 16'd0) ? PH_TAIL : PH_CID;
                                n_rem   = len;
                            end
                            PH_PTLEN: begin
                                n_phase = (len == 16'd0) ? PH_PMSG : PH_PTOPIC;
                                n_rem   = len;
                            end
                            PH_PID: begin
                                n_phase = PH_TLEN;
                                n_rem   = 16'd2;
                            end
                            default: begin
                                // Topic length of an entry or of the single topic.
                                if (len != 16'd0) begin
                                    n_phase = PH_TOPIC;
                                    n_rem   = len;
                                end else if (n_type == TYPE_SUBSCRIBE) begin
                                    n_phase = PH_SQOS;
                                    n_rem   = 16'd1;
                                end else begin
                                    n_phase = PH_TAIL;
                                    n_rem   = '0;
                                end
                            end
                        endcase
                    end
                end
                PH_CNAME: begin
                    if (b != proto_char(2'(16'd0 - rem))) begin
                        n_err   = 1'b1;
                        n_phase = PH_HALT;
                        n_rem   = '0;
                    end else if (done) begin
                        n_phase = PH_CSKIP;
                        n_rem   = 16'd2;
                    end else begin
                        n_rem = rem_dec;
                    end
                end
                PH_CSKIP: begin
                    if (done) begin
                        n_phase = PH_CKEEP;
                        n_rem   = 16'd2;
                    end else begin
                        n_rem = rem_dec;
                    end
                end
                PH_CKEEP: begin
                    n_keep = {n_keep[7:0], b};
                    if (done) begin
                        n_phase = PH_CIDLEN;
                        n_rem   = 16'd2;
                    end else begin
                        n_rem = rem_dec;
                    end
                end
                PH_CID: begin
                    s_kind = BK_CLIENT_ID;
                    n_rem  = rem_dec;
                    if (done) begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_PTOPIC: begin
                    s_kind = BK_TOPIC;
                    n_rem  = rem_dec;
                    if (done) begin
                        n_phase = PH_PMSG;
                    end
                end
                PH_PMSG: begin
                    s_kind = BK_MESSAGE;
                    n_hit  = 1'b1;
                end
                PH_TOPIC: begin
                    s_kind        = BK_TOPIC;
                    s_topic_entry = (n_type == TYPE_SUBSCRIBE) ? n_entry : 8'd0;
                    n_rem         = rem_dec;
                    if (done) begin
                        if (n_type == TYPE_SUBSCRIBE) begin
                            n_phase = PH_SQOS;
                            n_rem   = 16'd1;
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                end
                PH_SQOS: begin
                    if (b == 8'd0) begin
                        n_hit   = 1'b1;
                        n_phase = PH_HALT;
                        n_rem   = '0;
                    end else begin
                        if (n_entry < ENTRY_CAP) begin
                            n_entry = n_entry + 8'd1;
                        end
                        n_phase = PH_TLEN;
                        n_rem   = 16'd2;
                    end
                end
                PH_IDLE, PH_TAIL, PH_HALT: begin
                    n_phase = ph;
                end
            endcase
        end
    end

    always_comb begin : result_out
        o_result              = '0;
        o_result.byte_kind    = s_kind;
        o_result.byte_value   = (s_kind != BK_NONE) ? i_item.body_byte : 8'd0;
        o_result.topic_entry  = s_topic_entry;
        o_result.packet_done  = i_item.last_byte;
        if (i_item.last_byte) begin
            o_result.keep_alive = n_keep;
            unique case (n_type)
                TYPE_CONNECT: begin
                    o_result.packet_kind = PK_CONNECT;
                    o_result.accepted    = !n_err && (n_phase == PH_TAIL);
                    o_result.malformed   = !(!n_err && (n_phase == PH_TAIL));
                end
                TYPE_CONNACK: begin
                    o_result.packet_kind = PK_CONNACK;
                end
                TYPE_PUBLISH: begin
                    o_result.packet_kind = PK_PUBLISH;
                    o_result.accepted    = !n_err && (n_phase == PH_PMSG) && n_hit;
                    o_result.malformed   = !(!n_err && (n_phase == PH_PMSG) && n_hit);
                end
                TYPE_SUBSCRIBE: begin
                    o_result.packet_kind = PK_SUBSCRIBE;
                    // Ending cleanly on an entry boundary without a match is a rejection.
                    priority if (!n_err && n_hit) begin
                        o_result.accepted     = 1'b1;
                        o_result.chosen_entry = n_entry;
                    end else if (!n_err && (n_phase == PH_TLEN) && (n_rem == 16'd2)) begin
                        o_result.accepted = 1'b0;
                    end else begin
                        o_result.malformed = 1'b1;
                    end
                end
                TYPE_UNSUBSCRIBE: begin
                    o_result.packet_kind = PK_UNSUBSCRIBE;
                    o_result.accepted    = !n_err && (n_phase == PH_TAIL);
                    o_result.malformed   = !(!n_err && (n_phase == PH_TAIL));
                end
                TYPE_PINGREQ: begin
                    o_result.packet_kind = PK_PING;
                    o_result.accepted    = 1'b1;
                end
                default: begin
                    o_result.packet_kind = PK_OTHER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_shift <= '0;
            r_keep  <= '0;
            r_entry <= '0;
            r_err   <= 1'b0;
            r_hit   <= 1'b0;
            r_type  <= '0;
        end else if (i_step) begin
            r_phase <= i_item.last_byte ? PH_IDLE : n_phase;
            r_rem   <= n_rem;
            r_shift <= n_shift;
            r_keep  <= n_keep;
            r_entry <= n_entry;
            r_err   <= n_err;
            r_hit   <= n_hit;
            r_type  <= n_type;
        end
    end

endmodule

>>> hw/rtl/mpbp_checker.sv
// ----------------------------------------------------------------------------
// MQTT parser port checker
// Watches the top-level ports and flags results that break the parser rules.
// ----------------------------------------------------------------------------
module mpbp_checker
    import mpbp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [3:0]  i_packet_type,
    input logic [7:0]  i_body_byte,
    input logic        i_byte_present,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_byte_kind,
    input logic [7:0]  o_byte_value,
    input logic [7:0]  o_topic_entry,
    input logic        o_packet_done,
    input logic        o_accepted,
    input logic        o_malformed,
    input logic [2:0]  o_packet_kind,
    input logic [15:0] o_keep_alive,
    input logic [7:0]  o_chosen_entry
);

    // Nothing is left in the result register once reset has been applied.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_verdict_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_malformed))
        else $error("packet both accepted and malformed");

    // Verdict fields stay clear on results that do not end a packet.
    a_verdict_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_packet_done) |->
            (!o_accepted && !o_malformed && o_packet_kind == PK_OTHER &&
             o_keep_alive == 16'd0 && o_chosen_entry == 8'd0))
        else $error("verdict fields set before end of packet");

    a_no_byte_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_kind == BK_NONE) |->
            (o_byte_value == 8'd0 && o_topic_entry == 8'd0))
        else $error("byte value given with no streamed byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_byte_value) && $stable(o_packet_done)))
        else $error("stalled result changed");

endmodule

bind mqtt_packet_body_parser_top mpbp_checker u_mpbp_checker (.*);

>>> dv/mqtt_body_checker.sv
// ----------------------------------------------------------------------------
// MQTT packet body parser checker
// Watches the request and result channels of the parser, predicts the
// result of every request from its own copy of the parse state, and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mqtt_body_checker
    import mpbp_pkg::*;
#(
    parameter int unsigned ENTRY_INDEX_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_packet_type,
    input  logic [7:0]  i_body_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_byte_kind,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_topic_entry,
    input  logic        i_packet_done,
    input  logic        i_accepted,
    input  logic        i_malformed,
    input  logic [2:0]  i_packet_kind,
    input  logic [15:0] i_keep_alive,
    input  logic [7:0]  i_chosen_entry,
    output int          o_failures,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] PROTO_NAME = 32'h4D51_5454;
    localparam logic [7:0]  ENTRY_CAP  =
        (ENTRY_INDEX_MAX > 255) ? 8'd255 : 8'(ENTRY_INDEX_MAX);

    // Parse state of the packet body in progress.
    t_phase      phase;
    logic [15:0] field_left;
    logic [15:0] length_acc;
    logic [15:0] keep_alive_acc;
    logic [7:0]  entry_count;
    logic        error_seen;
    logic        hit_seen;
    logic [3:0]  body_type;

    t_result predicted_results[$];

    task automatic enter(input t_phase p, input logic [15:0] n);
        phase = p;
        field_left = n;
    endtask

    task automatic abort_body();
        error_seen = 1'b1;
        enter(PH_HALT, 16'd0);
    endtask

    task automatic count_byte(output logic done);
        if (field_left <= 16'd1) begin
            field_left = 16'd0;
            done = 1'b1;
        end else begin
            field_left = field_left - 16'd1;
            done = 1'b0;
        end
    endtask

    task automatic close_length(input logic [15:0] v);
        case (phase)
            PH_CNAMELEN: begin
                if (v != 16'd4) abort_body();
                else enter(PH_CNAME, 16'd4);
            end
            PH_CIDLEN: begin
                if (v == 16'd0) enter(PH_TAIL, 16'd0);
                else enter(PH_CID, v);
            end
            PH_PTLEN: begin
                if (v == 16'd0) enter(PH_PMSG, 16'd0);
                else enter(PH_PTOPIC, v);
            end
            PH_PID: enter(PH_TLEN, 16'd2);
            default: begin
                // A zero-length subscribe topic goes straight to its QoS byte.
                if (v != 16'd0) enter(PH_TOPIC, v);
                else if (body_type == TYPE_SUBSCRIBE) enter(PH_SQOS, 16'd1);
                else enter(PH_TAIL, 16'd0);
            end
        endcase
    endtask

    task automatic consume_byte(input logic [7:0] b, inout logic [1:0] kind,
                                inout logic [7:0] entry);
        logic        done;
        logic [15:0] v;
        logic [1:0]  idx;
        case (phase)
            PH_CNAMELEN, PH_CIDLEN, PH_PTLEN, PH_PID, PH_TLEN: begin
                length_acc = {length_acc[7:0], b};
                count_byte(done);
                if (done) begin
                    v = length_acc;
                    length_acc = 16'd0;
                    close_length(v);
                end
            end
            PH_CNAME: begin
                v = 16'd4 - field_left;
                idx = v[1:0];
                if (b != PROTO_NAME[31 - 8 * idx -: 8]) begin
                    abort_body();
                end else begin
                    count_byte(done);
                    if (done) enter(PH_CSKIP, 16'd2);
                end
            end
            PH_CSKIP: begin
                count_byte(done);
                if (done) enter(PH_CKEEP, 16'd2);
            end
            PH_CKEEP: begin
                keep_alive_acc = {keep_alive_acc[7:0], b};
                count_byte(done);
                if (done) enter(PH_CIDLEN, 16'd2);
            end
            PH_CID: begin
                kind = BK_CLIENT_ID;
                count_byte(done);
                if (done) enter(PH_TAIL, 16'd0);
            end
            PH_PTOPIC: begin
                kind = BK_TOPIC;
                count_byte(done);
                if (done) enter(PH_PMSG, 16'd0);
            end
            PH_PMSG: begin
                kind = BK_MESSAGE;
                hit_seen = 1'b1;
            end
            PH_TOPIC: begin
                kind = BK_TOPIC;
                entry = (body_type == TYPE_SUBSCRIBE) ? entry_count : 8'd0;
                count_byte(done);
                if (done) begin
                    if (body_type == TYPE_SUBSCRIBE) enter(PH_SQOS, 16'd1);
                    else enter(PH_TAIL, 16'd0);
                end
            end
            PH_SQOS: begin
                if (b == 8'd0) begin
                    hit_seen = 1'b1;
                    enter(PH_HALT, 16'd0);
                end else begin
                    if (entry_count < ENTRY_CAP) entry_count = entry_count + 8'd1;
                    enter(PH_TLEN, 16'd2);
                end
            end
            default: ;
        endcase
    endtask

    task automatic parse_request(input logic [3:0] ptype, input logic [7:0] b,
                                 input logic present, input logic last,
                                 output t_result r);
        logic [1:0] kind;
        logic [7:0] entry;
        kind = BK_NONE;
        entry = 8'd0;
        r = '0;
        if (phase == PH_IDLE) begin
            body_type = ptype;
            error_seen = 1'b0;
            hit_seen = 1'b0;
            keep_alive_acc = 16'd0;
            entry_count = 8'd0;
            length_acc = 16'd0;
            case (body_type)
                TYPE_CONNECT:                    enter(PH_CNAMELEN, 16'd2);
                TYPE_PUBLISH:                    enter(PH_PTLEN, 16'd2);
                TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE: enter(PH_PID, 16'd2);
                default:                         enter(PH_TAIL, 16'd0);
            endcase
        end
        if (present) consume_byte(b, kind, entry);
        r.byte_kind = kind;
        r.byte_value = (kind != BK_NONE) ? b : 8'd0;
        r.topic_entry = entry;
        r.packet_done = last;
        if (last) begin
            case (body_type)
                TYPE_CONNECT: begin
                    r.packet_kind = PK_CONNECT;
                    r.accepted = !error_seen && phase == PH_TAIL;
                    r.malformed = !r.accepted;
                end
                TYPE_CONNACK: r.packet_kind = PK_CONNACK;
                TYPE_PUBLISH: begin
                    r.packet_kind = PK_PUBLISH;
                    r.accepted = !error_seen && phase == PH_PMSG && hit_seen;
                    r.malformed = !r.accepted;
                end
                TYPE_SUBSCRIBE: begin
                    r.packet_kind = PK_SUBSCRIBE;
                    // Ending cleanly between entries without a QoS 0 entry
                    // is a plain rejection, anything else partial is malformed.
                    if (!error_seen && hit_seen) begin
                        r.accepted = 1'b1;
                        r.chosen_entry = entry_count;
                    end else if (!(!error_seen && phase == PH_TLEN
                                   && field_left == 16'd2)) begin
                        r.malformed = 1'b1;
                    end
                end
                TYPE_UNSUBSCRIBE: begin
                    r.packet_kind = PK_UNSUBSCRIBE;
                    r.accepted = !error_seen && phase == PH_TAIL;
                    r.malformed = !r.accepted;
                end
                TYPE_PINGREQ: begin
                    r.packet_kind = PK_PING;
                    r.accepted = 1'b1;
                end
                default: ;
            endcase
            r.keep_alive = keep_alive_acc;
            phase = PH_IDLE;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_failures++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            phase = PH_IDLE;
            field_left = 16'd0;
            length_acc = 16'd0;
            keep_alive_acc = 16'd0;
            entry_count = 8'd0;
            error_seen = 1'b0;
            hit_seen = 1'b0;
            body_type = 4'd0;
            predicted_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                parse_request(i_packet_type, i_body_byte, i_byte_present,
                              i_last_byte, want);
                predicted_results.insert(predicted_results.size(), want);
            end
            if (i_out_valid && !i_out_stall) begin
                seen = {i_byte_kind, i_byte_value, i_topic_entry, i_packet_done,
                        i_accepted, i_malformed, i_packet_kind, i_keep_alive,
                        i_chosen_entry};
                if (predicted_results.size() == 0) begin
                    $error("result with no request outstanding: %h", seen);
                    o_failures++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("byte_kind", 16'(want.byte_kind),
                                16'(seen.byte_kind));
                    check_field("byte_value", 16'(want.byte_value),
                                16'(seen.byte_value));
                    check_field("topic_entry", 16'(want.topic_entry),
                                16'(seen.topic_entry));
                    check_field("packet_done", 16'(want.packet_done),
                                16'(seen.packet_done));
                    check_field("accepted", 16'(want.accepted),
                                16'(seen.accepted));
                    check_field("malformed", 16'(want.malformed),
                                16'(seen.malformed));
                    check_field("packet_kind", 16'(want.packet_kind),
                                16'(seen.packet_kind));
                    check_field("keep_alive", want.keep_alive, seen.keep_alive);
                    check_field("chosen_entry", 16'(want.chosen_entry),
                                16'(seen.chosen_entry));
                    o_results++;
                end
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// MQTT packet body parser testbench
// Feeds directed and random packet bodies into the parser with random
// idling on both channels; the checker beside the block predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpbp_pkg::*;

    localparam int unsigned ENTRY_INDEX_MAX = 255;
    localparam int          RANDOM_ITEMS    = 800;
    localparam int          IDLE_LIMIT      = 1000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam logic [31:0] PROTO_NAME      = 32'h4D51_5454;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [3:0]  packet_type  = 4'd0;
    logic [7:0]  body_byte    = 8'd0;
    logic        byte_present = 1'b0;
    logic        last_byte    = 1'b0;
    logic        out_stall    = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  byte_kind;
    logic [7:0]  byte_value;
    logic [7:0]  topic_entry;
    logic        packet_done;
    logic        accepted;
    logic        malformed;
    logic [2:0]  packet_kind;
    logic [15:0] keep_alive;
    logic [7:0]  chosen_entry;

    int failures;
    int pending;
    int results;

    // Idling knobs, changed as the run goes through its phases.
    int gap_pct   = 0;
    int stall_pct = 0;
    bit quiet     = 1'b0;
    int stall_left = 0;

    int items_sent   = 0;
    int packet_count = 0;
    int type_count[16];
    int idle_cycles  = 0;

    logic [7:0] body[$];

    mqtt_packet_body_parser_top #(
        .ENTRY_INDEX_MAX(ENTRY_INDEX_MAX)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_packet_type (packet_type),
        .i_body_byte   (body_byte),
        .i_byte_present(byte_present),
        .i_last_byte   (last_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_byte_kind   (byte_kind),
        .o_byte_value  (byte_value),
        .o_topic_entry (topic_entry),
        .o_packet_done (packet_done),
        .o_accepted    (accepted),
        .o_malformed   (malformed),
        .o_packet_kind (packet_kind),
        .o_keep_alive  (keep_alive),
        .o_chosen_entry(chosen_entry)
    );

    mqtt_body_checker #(
        .ENTRY_INDEX_MAX(ENTRY_INDEX_MAX)
    ) i_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_packet_type (packet_type),
        .i_body_byte   (body_byte),
        .i_byte_present(byte_present),
        .i_last_byte   (last_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_byte_kind   (byte_kind),
        .i_byte_value  (byte_value),
        .i_topic_entry (topic_entry),
        .i_packet_done (packet_done),
        .i_accepted    (accepted),
        .i_malformed   (malformed),
        .i_packet_kind (packet_kind),
        .i_keep_alive  (keep_alive),
        .i_chosen_entry(chosen_entry),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_results     (results)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Result side: stall in bursts of random length.
    always @(posedge clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("No request or result moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [3:0] t, input logic [7:0] b,
                             input logic present, input logic last);
        if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        packet_type <= t;
        body_byte <= b;
        byte_present <= present;
        last_byte <= last;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Sends the bytes in body as one packet. A noisy packet changes its type
    // after the first request and slips in requests that carry no byte.
    task automatic send_packet(input logic [3:0] ptype, input bit noisy,
                               input bit end_empty);
        logic [3:0] cur;
        int         n;
        int         i;
        cur = ptype;
        n = body.size();
        for (i = 0; i < n; i++) begin
            if (noisy && i > 0) begin
                cur = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 7) == 0) send_item(cur, 8'($urandom), 1'b0, 1'b0);
            end
            send_item(cur, body[i], 1'b1, i == n - 1 && !end_empty);
        end
        if (n == 0 || end_empty) send_item(cur, 8'($urandom), 1'b0, 1'b1);
        packet_count++;
        type_count[ptype]++;
    endtask

    task automatic add_byte(input logic [7:0] v);
        body.insert(body.size(), v);
    endtask

    task automatic put16(input logic [15:0] v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endtask

    task automatic put_random(input int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int base;
        int done;
        int progress;
        int long_items;
        int mark;
        int pick;
        int flaw;
        int len;
        int entries;
        int zero_at;
        int cut;
        int k;
        bit paused;
        logic [3:0] ptype;

        long_items = 0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 10;
        stall_pct = 10;
        // Empty bodies: a ping is accepted, a connect is malformed.
        body.delete();
        send_packet(TYPE_PINGREQ, 1'b0, 1'b0);
        send_packet(TYPE_CONNECT, 1'b0, 1'b0);
        body = '{8'hFF};
        send_packet(TYPE_CONNACK, 1'b0, 1'b0);
        // Full connect with the largest keep-alive, type noise on later bytes.
        body = '{8'h00, 8'h04, 8'h4D, 8'h51, 8'h54, 8'h54, 8'h04, 8'hC2,
                 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80};
        send_packet(TYPE_CONNECT, 1'b1, 1'b0);
        // Second entry has a zero-length topic and QoS 0.
        body = '{8'h12, 8'h34, 8'h00, 8'h01, 8'h78, 8'h01, 8'h00, 8'h00, 8'h00};
        send_packet(TYPE_SUBSCRIBE, 1'b0, 1'b0);
        // Subscribe with only its identifier: rejected, not malformed.
        body = '{8'h00, 8'h00};
        send_packet(TYPE_SUBSCRIBE, 1'b0, 1'b0);
        // Protocol name length other than 4.
        body = '{8'h00, 8'h05};
        send_packet(TYPE_CONNECT, 1'b0, 1'b0);
        wait_drained();

        base = items_sent;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            progress = done * 100 / RANDOM_ITEMS;
            if (progress < 35) begin
                gap_pct = 15;
                stall_pct = 15;
            end else if (progress < 50) begin
                gap_pct = 0;
                stall_pct = 0;
            end else if (progress < 80) begin
                gap_pct = 30;
                stall_pct = 40;
            end else begin
                quiet = 1'b1;
                gap_pct = 0;
                stall_pct = 0;
            end
            if (progress >= 50 && !paused) begin
                paused = 1'b1;
                wait_drained();
            end

            body.delete();
            if (progress >= 40 && long_items == 0) begin
                // Enough entries without QoS 0 to saturate the entry index.
                mark = items_sent;
                put16(16'h0001);
                repeat (260) begin
                    put16(16'h0000);
                    add_byte(8'h01);
                end
                put16(16'h0001);
                add_byte(8'h7A);
                add_byte(8'h00);
                send_packet(TYPE_SUBSCRIBE, 1'b0, 1'b0);
                long_items = items_sent - mark;
                body.delete();
            end

            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                ptype = TYPE_CONNECT;
                put16(16'd4);
                for (k = 0; k < 4; k++) add_byte(PROTO_NAME[31 - 8 * k -: 8]);
                put_random(2);
                case ($urandom_range(0, 3))
                    0: put16(16'h0000);
                    1: put16(16'hFFFF);
                    default: put16(16'($urandom));
                endcase
                len = $urandom_range(0, 6);
                put16(16'(len));
                put_random(len);
            end else if (pick < 50) begin
                ptype = TYPE_PUBLISH;
                len = $urandom_range(0, 6);
                put16(16'(len));
                put_random(len);
                put_random($urandom_range(1, 8));
            end else if (pick < 70) begin
                ptype = TYPE_SUBSCRIBE;
                put16(16'($urandom));
                entries = $urandom_range(1, 4);
                // An index past the last entry leaves no QoS 0 entry.
                zero_at = $urandom_range(0, 5);
                for (k = 0; k < entries; k++) begin
                    len = $urandom_range(0, 4);
                    put16(16'(len));
                    put_random(len);
                    add_byte(k == zero_at ? 8'h00 : 8'($urandom_range(1, 255)));
                end
            end else if (pick < 82) begin
                ptype = TYPE_UNSUBSCRIBE;
                put16(16'($urandom));
                len = $urandom_range(0, 6);
                put16(16'(len));
                put_random(len);
            end else if (pick < 88) begin
                ptype = TYPE_PINGREQ;
                put_random($urandom_range(0, 2));
            end else begin
                ptype = 4'($urandom_range(0, 15));
                put_random($urandom_range(0, 3));
            end

            flaw = $urandom_range(0, 99);
            if (flaw < 8 && body.size() > 0) begin
                cut = $urandom_range(1, body.size());
                repeat (cut) body.delete(body.size() - 1);
            end else if (flaw < 12) begin
                body.delete();
                put_random($urandom_range(1, 12));
            end else if (flaw < 16 && ptype == TYPE_CONNECT) begin
                body[$urandom_range(0, 5)] = 8'($urandom);
            end else if (flaw < 22) begin
                put_random($urandom_range(1, 4));
            end
            send_packet(ptype, $urandom_range(0, 9) == 0, $urandom_range(0, 15) == 0);
            done = items_sent - base - long_items;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d requests in %0d packet bodies, %0d results checked, %0d mismatches",
                 items_sent, packet_count, results, failures);
        $display("Bodies by type: connect %0d, publish %0d, subscribe %0d,",
                 type_count[TYPE_CONNECT], type_count[TYPE_PUBLISH],
                 type_count[TYPE_SUBSCRIBE]);
        $display("  unsubscribe %0d, ping %0d",
                 type_count[TYPE_UNSUBSCRIBE], type_count[TYPE_PINGREQ]);
        if (failures == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mpbp_pkg.sv
hw/rtl/mpbp_parse_core.sv
hw/rtl/mqtt_packet_body_parser_top.sv
hw/rtl/mpbp_checker.sv
dv/mqtt_body_checker.sv
dv/tb.sv
